// ===== hw/rtl/rgb_sharpen_convolution_assert.svh =====
// assertion macros for the rgb sharpen block
// expects signals named clk and rst in the including module
`ifndef RGB_SHARPEN_CONVOLUTION_ASSERT_SVH
`define RGB_SHARPEN_CONVOLUTION_ASSERT_SVH

`ifndef SYNTHESIS

`define RGBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgbs assertion failed");

`define RGBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgbs assertion failed");

`else

`define RGBS_ASSERT_IMP(label, ante, cons)

`define RGBS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/rgbs_pkg.sv =====
// shared types and constants for the rgb sharpen block
// no dependencies
package rgbs_pkg;

  typedef logic [23:0] pixel_t;
  typedef logic [1:0]  cfg_index_t;
  typedef logic [12:0] cfg_data_t;

  typedef struct packed {
    logic             big;
    pixel_t           centre;
    pixel_t [7:0]     nbr;
  } taps_t;

  localparam cfg_index_t REG_KERNEL_SELECT = 2'd0;
  localparam cfg_index_t REG_FRAME_WIDTH   = 2'd1;
  localparam cfg_index_t REG_FRAME_HEIGHT  = 2'd2;

  localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [12:0] MIN_SIZE         = 13'd5;
  localparam logic [12:0] MAX_HEIGHT       = 13'd4096;
  localparam logic [12:0] PIX_MAX          = 13'd255;

endpackage

// ===== hw/rtl/rgbs_filter.sv =====
// per-channel sharpening sum and clamp over the selected window taps
// depends on rgbs_pkg
module rgbs_filter (
  input  rgbs_pkg::taps_t taps,
  output rgbs_pkg::pixel_t result
);
  import rgbs_pkg::*;

  always_comb begin
    logic signed [12:0] acc;
    logic [12:0] weight;
    weight = taps.big ? 13'd9 : 13'd5;
    result = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = $signed(weight * {5'b0, taps.centre[ch*8 +: 8]});
      for (int n = 0; n < 8; n++) begin
        acc = acc - $signed({5'b0, taps.nbr[n][ch*8 +: 8]});
      end
      if (acc[12]) begin
        result[ch*8 +: 8] = 8'd0;
      end else if (acc > $signed(PIX_MAX)) begin
        result[ch*8 +: 8] = 8'd255;
      end else begin
        result[ch*8 +: 8] = acc[7:0];
      end
    end
  end

endmodule

// ===== hw/rtl/rgb_sharpen_convolution.sv =====
// rgb sharpen convolution top level: line store memory, 5x5 window, output register
// stages 1 and 2, then the output register; one pixel per cycle unless the output
// stalls, set by the single read-modify-write of the line store word at its column
// reset clears counters, pipeline valids and window and loads register defaults;
// the line store is not cleared, stale entries never reach a result
// depends on rgbs_pkg, rgbs_filter and rgb_sharpen_convolution_assert.svh
`include "rgb_sharpen_convolution_assert.svh"

module rgb_sharpen_convolution #(
  parameter int MAX_WIDTH   = 1024,
  parameter int LINE_STORES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  rgbs_pkg::cfg_index_t  cfg_index,
  input  rgbs_pkg::cfg_data_t   cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  rgbs_pkg::pixel_t      s_tdata,   // in_red, in_green, in_blue
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output rgbs_pkg::pixel_t      m_tdata,   // out_red, out_green, out_blue
  output logic                  m_tlast
);
  import rgbs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic              kernel_select;
  logic [10:0]       frame_width;
  logic [12:0]       frame_height;
  logic [CW:0]       w_eff;
  logic [12:0]       h_eff;
  logic [CW-1:0]     col_count;
  logic [11:0]       row_count;
  logic              adv;
  logic              accept;
  logic              restart;
  logic              col_wrap;
  logic              row_wrap;
  logic [12:0]       k2;

  logic              s1_valid;
  pixel_t            s1_px;
  logic [CW-1:0]     s1_col;
  logic              s1_emit;
  logic              s1_last;
  logic              s2_valid;
  logic              s2_emit;
  logic              s2_last;

  logic [LINE_STORES-1:0][23:0] line_mem [MAX_WIDTH];
  logic [LINE_STORES-1:0][23:0] rd_word;
  logic [LINE_STORES-1:0][23:0] new_word;
  pixel_t            col_vec [5];
  pixel_t            win [5][5];
  taps_t             taps;
  pixel_t            filt;

  // effective frame size
  always_comb begin
    if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else if (frame_width < 11'(MIN_SIZE)) begin
      w_eff = (CW+1)'(MIN_SIZE);
    end else begin
      w_eff = (CW+1)'(frame_width);
    end
    if (frame_height > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else if (frame_height < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else begin
      h_eff = frame_height;
    end
  end

  assign adv      = !m_tvalid || m_tready || !(s2_valid && s2_emit);
  assign s_tready = adv;
  assign accept   = s_tvalid && adv;
  assign restart  = cfg_we && (cfg_index == REG_KERNEL_SELECT ||
                    cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  assign col_wrap = ({1'b0, col_count} + 1'b1) == w_eff;
  assign row_wrap = ({1'b0, row_count} + 1'b1) == h_eff;
  assign k2       = kernel_select ? 13'd4 : 13'd2;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= 1'b0;
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KERNEL_SELECT: kernel_select <= cfg_data[0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[10:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? 12'd0 : row_count + 12'd1;
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // stage 1: line store read issued with the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= s_tdata;
      s1_col  <= col_count;
      s1_emit <= (13'(row_count) >= k2) && (13'(col_count) >= k2);
      s1_last <= row_wrap && col_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_word <= line_mem[col_count];
    end
  end

  // line store write back, oldest line drops out
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      line_mem[s1_col] <= new_word;
    end
  end

  assign new_word[0] = s1_px;
  assign col_vec[4]  = s1_px;

  for (genvar g = 1; g < LINE_STORES; g++) begin : g_shift
    assign new_word[g] = rd_word[g-1];
  end

  for (genvar g = 0; g < 4; g++) begin : g_col
    if (3 - g < LINE_STORES) begin : g_stored
      assign col_vec[g] = rd_word[3-g];
    end else begin : g_zero
      assign col_vec[g] = '0;
    end
  end

  // stage 2: window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 5; r++) begin
        for (int j = 0; j < 5; j++) begin
          win[r][j] <= '0;
        end
      end
    end else if (adv && s1_valid) begin
      for (int r = 0; r < 5; r++) begin
        for (int j = 0; j < 4; j++) begin
          win[r][j] <= win[r][j+1];
        end
        win[r][4] <= col_vec[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_emit <= s1_emit;
      s2_last <= s1_last;
    end
  end

  // tap selection
  always_comb begin
    taps.big = kernel_select;
    if (kernel_select) begin
      taps.centre = win[2][2];
      taps.nbr[0] = win[0][2];
      taps.nbr[1] = win[1][2];
      taps.nbr[2] = win[3][2];
      taps.nbr[3] = win[4][2];
      taps.nbr[4] = win[2][0];
      taps.nbr[5] = win[2][1];
      taps.nbr[6] = win[2][3];
      taps.nbr[7] = win[2][4];
    end else begin
      taps.centre = win[3][3];
      taps.nbr[0] = win[2][3];
      taps.nbr[1] = win[4][3];
      taps.nbr[2] = win[3][2];
      taps.nbr[3] = win[3][4];
      taps.nbr[4] = '0;
      taps.nbr[5] = '0;
      taps.nbr[6] = '0;
      taps.nbr[7] = '0;
    end
  end

  rgbs_filter u_filter (
    .taps   (taps),
    .result (filt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && s2_valid && s2_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_emit) begin
      m_tdata <= filt;
      m_tlast <= s2_last;
    end
  end

  `RGBS_ASSERT_NEXT(a_restart_clears, restart, col_count == '0 && row_count == '0)
  `RGBS_ASSERT_IMP(a_col_in_frame, 1'b1, {1'b0, col_count} < w_eff)
  `RGBS_ASSERT_NEXT(a_stall_holds_window, !adv, $stable(win[2][2]) && $stable(s2_valid))

endmodule
